// ----- hdl/dzsm_pkg.sv -----
// dzsm_pkg: widths, constants and the divider cell payload for the
// dead-zone speed map; no dependencies, imported by every hdl module
package dzsm_pkg;

  localparam int SAMPLE_BITS = 13;
  localparam int UW          = SAMPLE_BITS - 1;   // magnitude bits once clamped
  localparam int DZ_W        = 6;
  localparam int SPEED_W     = 7;

  localparam logic [DZ_W-1:0] DZ_RESET = DZ_W'(10);

  // size = ref * dz / 100 by reciprocal with one correction step
  localparam int PROD_W      = UW + DZ_W;
  localparam int DZ_DIV      = 100;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP       = (1 << RECIP_SHIFT) / DZ_DIV;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int RP_W        = PROD_W + RECIP_W;

  // raw percentage num*100/den mapped through q = num*500/den
  localparam int QW          = 9;                 // q never exceeds 500
  localparam int NW          = UW + QW;
  localparam int NUM_MULT    = 500;
  localparam int TINY        = 1000;              // num*1000 <= den means pct <= 0.1
  localparam int TINY_W      = UW + 10;
  localparam int SLOW_NUM    = 10;                // pct < 90  <=>  10*num < 9*den
  localparam int SLOW_DEN    = 9;
  localparam int SLOW_W      = UW + 4;
  localparam int FAST_OFFSET = 400;
  localparam int DIV9_MULT   = 456;               // q/9 as (q*456)>>12, exact for q < 512
  localparam int DIV9_SHIFT  = 12;
  localparam int DIV9_W      = QW + 9;

  localparam int PREP_STAGES = 6;
  localparam int NCELLS      = QW;

  typedef logic [UW-1:0] mag_t;

  typedef struct packed {
    mag_t          rem;
    mag_t          den;
    logic [QW-1:0] nlow;
    logic [QW-1:0] quo;
    logic          zero;
    logic          slow;
    logic          dir;
  } cell_data_t;

endpackage

// ----- hdl/dzsm_prep.sv -----
// dzsm_prep: clamping, dead-zone thresholds and zone selection ahead of the
// divider chain; six registered stages; depends on dzsm_pkg
module dzsm_prep (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [dzsm_pkg::DZ_W-1:0]             dead_zone_percent,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [dzsm_pkg::SAMPLE_BITS-1:0] pot_sample,
  input  logic signed [dzsm_pkg::SAMPLE_BITS-1:0] full_scale_ref,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output dzsm_pkg::cell_data_t                  out_data
);
  import dzsm_pkg::*;

  logic [PREP_STAGES-1:0] v_r, v_nxt, en;

  mag_t              s1_s_r, s1_ref_r, s1_s_nxt, s1_ref_nxt;
  logic [PROD_W-1:0] s1_prod_r, s1_prod_nxt;
  mag_t              s2_s_r, s2_ref_r;
  logic [PROD_W-1:0] s2_prod_r, s2_q0_r, s2_q0_nxt;
  logic [RP_W-1:0]   recip_prod;
  mag_t              s3_s_r, s3_ref_r, s3_size_r, s3_size_nxt;
  logic [PROD_W-1:0] corr_rem;
  mag_t              s4_s_r, s4_ref_r, s4_lo_r, s4_hi_r, s4_lo_nxt, s4_hi_nxt;
  mag_t              mid, half;
  mag_t              s5_num_r, s5_den_r, s5_num_nxt, s5_den_nxt;
  logic              s5_dir_r, s5_act_r, fwd, bwd;
  logic [NW-1:0]     big_num;
  cell_data_t        s6_data_r, s6_data_nxt;

  // stage holds still only when full and the next one cannot take it
  always_comb begin
    en[PREP_STAGES-1] = !v_r[PREP_STAGES-1] || out_ready;
    for (int i = PREP_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int i = 1; i < PREP_STAGES; i++) begin
      if (en[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[PREP_STAGES-1];
  assign out_data  = s6_data_r;

  // clamp; a nonpositive reference leaves the sample at zero
  always_comb begin
    if (pot_sample < 0) begin
      s1_s_nxt = '0;
    end else if (pot_sample > full_scale_ref) begin
      s1_s_nxt = (full_scale_ref < 0) ? '0 : full_scale_ref[UW-1:0];
    end else begin
      s1_s_nxt = pot_sample[UW-1:0];
    end
    s1_ref_nxt  = (full_scale_ref <= 0) ? mag_t'(1) : full_scale_ref[UW-1:0];
    s1_prod_nxt = PROD_W'(s1_ref_nxt) * PROD_W'(dead_zone_percent);
  end

  always_comb begin
    recip_prod = RP_W'(s1_prod_r) * RP_W'(RECIP);
    s2_q0_nxt  = PROD_W'(recip_prod >> RECIP_SHIFT);
  end

  // reciprocal estimate is low by at most one
  always_comb begin
    corr_rem    = s2_prod_r - PROD_W'(s2_q0_r * PROD_W'(DZ_DIV));
    s3_size_nxt = UW'(s2_q0_r + PROD_W'(corr_rem >= PROD_W'(DZ_DIV)));
  end

  always_comb begin
    mid       = s3_ref_r >> 1;
    half      = s3_size_r >> 1;
    s4_lo_nxt = mid - half;
    s4_hi_nxt = mid + half;
  end

  always_comb begin
    fwd = (s4_s_r > s4_hi_r) && (s4_ref_r > s4_hi_r);
    bwd = (s4_s_r < s4_lo_r) && (s4_lo_r != '0);
    if (fwd) begin
      s5_num_nxt = s4_s_r - s4_hi_r;
      s5_den_nxt = s4_ref_r - s4_hi_r;
    end else begin
      s5_num_nxt = s4_lo_r - s4_s_r;
      s5_den_nxt = s4_lo_r;
    end
  end

  always_comb begin
    big_num          = NW'(s5_num_r) * NW'(NUM_MULT);
    s6_data_nxt.rem  = big_num[NW-1:QW];
    s6_data_nxt.nlow = big_num[QW-1:0];
    s6_data_nxt.den  = s5_den_r;
    s6_data_nxt.quo  = '0;
    s6_data_nxt.zero = !s5_act_r ||
                       (TINY_W'(s5_num_r) * TINY_W'(TINY) <= TINY_W'(s5_den_r));
    s6_data_nxt.slow = SLOW_W'(s5_num_r) * SLOW_W'(SLOW_NUM) <
                       SLOW_W'(s5_den_r) * SLOW_W'(SLOW_DEN);
    s6_data_nxt.dir  = s5_dir_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_s_r    <= s1_s_nxt;
      s1_ref_r  <= s1_ref_nxt;
      s1_prod_r <= s1_prod_nxt;
    end
    if (en[1]) begin
      s2_s_r    <= s1_s_r;
      s2_ref_r  <= s1_ref_r;
      s2_prod_r <= s1_prod_r;
      s2_q0_r   <= s2_q0_nxt;
    end
    if (en[2]) begin
      s3_s_r    <= s2_s_r;
      s3_ref_r  <= s2_ref_r;
      s3_size_r <= s3_size_nxt;
    end
    if (en[3]) begin
      s4_s_r    <= s3_s_r;
      s4_ref_r  <= s3_ref_r;
      s4_lo_r   <= s4_lo_nxt;
      s4_hi_r   <= s4_hi_nxt;
    end
    if (en[4]) begin
      s5_num_r  <= s5_num_nxt;
      s5_den_r  <= s5_den_nxt;
      s5_dir_r  <= fwd;
      s5_act_r  <= fwd || bwd;
    end
    if (en[5]) begin
      s6_data_r <= s6_data_nxt;
    end
  end

endmodule

// ----- hdl/dzsm_cell.sv -----
// dzsm_cell: one restoring division step, one quotient bit per cell, with its
// own valid/ready stage register; depends on dzsm_pkg
module dzsm_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dzsm_pkg::cell_data_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dzsm_pkg::cell_data_t out_data
);
  import dzsm_pkg::*;

  logic          v_r, v_nxt, en, ge;
  logic [UW:0]   trial;
  cell_data_t    d_r, d_nxt;

  assign en       = !v_r || out_ready;
  assign in_ready = en;
  assign v_nxt    = en ? in_valid : v_r;

  // bring down the next dividend bit and try the subtraction
  always_comb begin
    trial     = {in_data.rem, in_data.nlow[QW-1]};
    ge        = trial >= {1'b0, in_data.den};
    d_nxt     = in_data;
    d_nxt.rem = ge ? UW'(trial - {1'b0, in_data.den}) : trial[UW-1:0];
    d_nxt.nlow = {in_data.nlow[QW-2:0], 1'b0};
    d_nxt.quo  = {in_data.quo[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

// ----- hdl/dzsm_map.sv -----
// dzsm_map: turns the quotient num*500/den into the speed percentage and
// holds the result in the output register; depends on dzsm_pkg
module dzsm_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dzsm_pkg::cell_data_t          in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dzsm_pkg::SPEED_W-1:0]  speed_percent,
  output logic                          direction
);
  import dzsm_pkg::*;

  logic               v_r, v_nxt, en, dir_r;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic [DIV9_W-1:0]  div9;
  logic [QW-1:0]      fast;

  assign en       = !v_r || out_ready;
  assign in_ready = en;
  assign v_nxt    = en ? in_valid : v_r;

  // a set zero flag gives zero speed; below 90 percent the quotient is divided by nine, otherwise offset by 400
  always_comb begin
    div9 = DIV9_W'(in_data.quo) * DIV9_W'(DIV9_MULT);
    fast = in_data.quo - QW'(FAST_OFFSET);
    if (in_data.zero) begin
      speed_nxt = '0;
    end else if (in_data.slow) begin
      speed_nxt = SPEED_W'(div9 >> DIV9_SHIFT);
    end else begin
      speed_nxt = fast[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      speed_r <= speed_nxt;
      dir_r   <= in_data.dir;
    end
  end

  assign out_valid     = v_r;
  assign speed_percent = speed_r;
  assign direction     = dir_r;

endmodule

// ----- hdl/pot_dead_zone_speed_map.sv -----
// pot_dead_zone_speed_map: top level; prep stages, a chain of nine divider
// cells and the output stage; depends on dzsm_pkg, dzsm_prep, dzsm_cell, dzsm_map
// path: prep stages, then the divider cells, then the registered output stage
// throughput: one transaction per cycle while out_ready is high, every stage and cell has its own valid bit
// the divider chain resolves one quotient bit per cell, nine cells in all
// reset: synchronous active-low rst_n empties the pipeline, dead zone returns to 10
module pot_dead_zone_speed_map (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dzsm_pkg::DZ_W-1:0]             cfg_dead_zone_percent,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [dzsm_pkg::SAMPLE_BITS-1:0] in_pot_sample,
  input  logic signed [dzsm_pkg::SAMPLE_BITS-1:0] in_full_scale_ref,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dzsm_pkg::SPEED_W-1:0]          out_speed_percent,
  output logic                                  out_direction
);
  import dzsm_pkg::*;

  logic [DZ_W-1:0] dz_r, dz_nxt;
  logic            chain_v   [NCELLS+1];
  logic            chain_rdy [NCELLS+1];
  cell_data_t      chain_d   [NCELLS+1];

  assign cfg_ready = 1'b1;
  assign dz_nxt    = cfg_valid ? cfg_dead_zone_percent : dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
    end else begin
      dz_r <= dz_nxt;
    end
  end

  dzsm_prep u_prep (
    .clk               (clk),
    .rst_n             (rst_n),
    .dead_zone_percent (dz_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .pot_sample        (in_pot_sample),
    .full_scale_ref    (in_full_scale_ref),
    .out_valid         (chain_v[0]),
    .out_ready         (chain_rdy[0]),
    .out_data          (chain_d[0])
  );

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    dzsm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_v[i]),
      .in_ready  (chain_rdy[i]),
      .in_data   (chain_d[i]),
      .out_valid (chain_v[i+1]),
      .out_ready (chain_rdy[i+1]),
      .out_data  (chain_d[i+1])
    );
  end

  dzsm_map u_map (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (chain_v[NCELLS]),
    .in_ready      (chain_rdy[NCELLS]),
    .in_data       (chain_d[NCELLS]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .speed_percent (out_speed_percent),
    .direction     (out_direction)
  );

endmodule

// ----- hdl/dzsm_checker.sv -----
// dzsm_checker: port-level assertions for pot_dead_zone_speed_map and the bind
// that attaches them; depends on dzsm_pkg
module dzsm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dzsm_pkg::SPEED_W-1:0] out_speed_percent,
  input logic                         out_direction
);
  import dzsm_pkg::*;

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // with the output stage empty every stage can move, so input is taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_speed_percent <= SPEED_W'(100)))
    else $error("speed above 100 percent");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_speed_percent) && $stable(out_direction))
    else $error("stalled result changed");

endmodule

bind pot_dead_zone_speed_map dzsm_checker u_dzsm_checker (.*);
